// ===== src/assert_macros.svh =====
// Assertion macros used by the block's top-level RTL file.
// Checks compile to nothing when SYNTHESIS is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define RHD_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rhd assertion failed");
`define RHD_ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("rhd forbidden condition seen");
`else
`define RHD_ASSERT(lbl, clk, rst, prop)
`define RHD_ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

// ===== src/rhd_pkg.sv =====
`timescale 1ns / 1ps
// Shared widths, constants and types for the RGB/HSV decompose pipeline.
// No dependencies.
package rhd_pkg;

  localparam int PIX_W          = 8;
  localparam int NUM_W          = 17;
  localparam int DEN_W          = 9;
  localparam int QUO_W          = 8;
  localparam int DIV_STAGES     = 4;
  localparam int BITS_PER_STAGE = QUO_W / DIV_STAGES;
  localparam int FRONT_STAGES   = 2;
  localparam int PIPE_STAGES    = FRONT_STAGES + DIV_STAGES;

  localparam logic [NUM_W-1:0] HUE_SCALE = NUM_W'(85);
  localparam logic [NUM_W-1:0] SAT_SCALE = NUM_W'(255);

  localparam logic MODE_RGB = 1'b0;
  localparam logic MODE_HSV = 1'b1;

  typedef enum logic [1:0] {
    SEC_RED,
    SEC_GREEN,
    SEC_BLUE
  } sector_t;

  typedef struct packed {
    logic             mode;
    logic [PIX_W-1:0] red;
    logic [PIX_W-1:0] green;
    logic [PIX_W-1:0] third;
  } side_t;

endpackage

// ===== src/rhd_pixel_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: RGB pixel in, three planes out.
// Standalone; no package dependency.
interface rhd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  output ready);
endinterface

interface rhd_plane_if;
  logic       valid;
  logic       ready;
  logic [7:0] first_plane;
  logic [7:0] second_plane;
  logic [7:0] third_plane;

  modport source (output valid, output first_plane, output second_plane,
                  output third_plane, input ready);
  modport sink   (input valid, input first_plane, input second_plane,
                  input third_plane, output ready);
endinterface

// ===== src/rhd_front.sv =====
`timescale 1ns / 1ps
// Front end: max/min/sector (stage 0), then dividends and divisors (stage 1).
// Depends on rhd_pkg.
module rhd_front (
  input  logic                        clk,
  input  logic [rhd_pkg::FRONT_STAGES-1:0] en,
  input  logic                        mode,
  input  logic [rhd_pkg::PIX_W-1:0]   red,
  input  logic [rhd_pkg::PIX_W-1:0]   green,
  input  logic [rhd_pkg::PIX_W-1:0]   blue,
  output rhd_pkg::side_t              side,
  output logic [rhd_pkg::NUM_W-1:0]   num_hue,
  output logic [rhd_pkg::DEN_W-1:0]   den_hue,
  output logic [rhd_pkg::NUM_W-1:0]   num_sat,
  output logic [rhd_pkg::DEN_W-1:0]   den_sat
);
  import rhd_pkg::*;

  // stage 0
  side_t                    side0;
  logic [PIX_W-1:0]         mx0;
  logic [PIX_W-1:0]         delta0;
  sector_t                  sel0;
  logic signed [PIX_W:0]    diff0;

  logic [PIX_W-1:0]         mx_next;
  logic [PIX_W-1:0]         mn_next;
  sector_t                  sel_next;
  logic signed [PIX_W:0]    diff_next;

  always_comb begin
    mx_next = red;
    if (green > mx_next) mx_next = green;
    if (blue > mx_next) mx_next = blue;
    mn_next = red;
    if (green < mn_next) mn_next = green;
    if (blue < mn_next) mn_next = blue;
    // ties go to red, then green
    if (red == mx_next) begin
      sel_next  = SEC_RED;
      diff_next = $signed({1'b0, green}) - $signed({1'b0, blue});
    end else if (green == mx_next) begin
      sel_next  = SEC_GREEN;
      diff_next = $signed({1'b0, blue}) - $signed({1'b0, red});
    end else begin
      sel_next  = SEC_BLUE;
      diff_next = $signed({1'b0, red}) - $signed({1'b0, green});
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      side0.mode  <= mode;
      side0.red   <= red;
      side0.green <= green;
      side0.third <= (mode == MODE_HSV) ? mx_next : blue;
      mx0         <= mx_next;
      delta0      <= mx_next - mn_next;
      sel0        <= sel_next;
      diff0       <= diff_next;
    end
  end

  // stage 1: hue dividend 85*(k*delta + d), wrapped by 6*delta when negative
  logic signed [PIX_W+3:0]  d_ext;
  logic signed [PIX_W+3:0]  dl_ext;
  logic signed [PIX_W+3:0]  x_s;
  logic [NUM_W-1:0]         x_u;

  always_comb begin
    d_ext  = $signed({{3{diff0[PIX_W]}}, diff0});
    dl_ext = $signed({4'b0, delta0});
    case (sel0)
      SEC_RED: begin
        x_s = d_ext;
        if (diff0 < 0) x_s = d_ext + (dl_ext <<< 2) + (dl_ext <<< 1);
      end
      SEC_GREEN: x_s = d_ext + (dl_ext <<< 1);
      SEC_BLUE:  x_s = d_ext + (dl_ext <<< 2);
      default:   x_s = d_ext;
    endcase
    x_u = NUM_W'(x_s[PIX_W+2:0]);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      side <= side0;
      if (delta0 == '0) begin
        num_hue <= '0;
        den_hue <= DEN_W'(1);
        num_sat <= '0;
        den_sat <= DEN_W'(1);
      end else begin
        num_hue <= x_u * HUE_SCALE;
        den_hue <= {delta0, 1'b0};
        num_sat <= NUM_W'(delta0) * SAT_SCALE;
        den_sat <= {1'b0, mx0};
      end
    end
  end

endmodule

// ===== src/rhd_div.sv =====
`timescale 1ns / 1ps
// Pipelined restoring divider, a fixed number of quotient bits per stage.
// Depends on rhd_pkg; dividend must be below divisor * 2**QUO_W.
module rhd_div (
  input  logic                            clk,
  input  logic [rhd_pkg::DIV_STAGES-1:0]  en,
  input  logic [rhd_pkg::NUM_W-1:0]       num,
  input  logic [rhd_pkg::DEN_W-1:0]       den,
  output logic [rhd_pkg::QUO_W-1:0]       quo
);
  import rhd_pkg::*;

  logic [NUM_W-1:0] rem  [DIV_STAGES];
  logic [DEN_W-1:0] dvsr [DIV_STAGES];
  logic [QUO_W-1:0] qacc [DIV_STAGES];

  logic [NUM_W-1:0] rem_in    [DIV_STAGES];
  logic [DEN_W-1:0] dvsr_in   [DIV_STAGES];
  logic [QUO_W-1:0] qacc_in   [DIV_STAGES];
  logic [NUM_W-1:0] rem_next  [DIV_STAGES];
  logic [QUO_W-1:0] qacc_next [DIV_STAGES];

  always_comb begin
    rem_in[0]  = num;
    dvsr_in[0] = den;
    qacc_in[0] = '0;
    for (int s = 1; s < DIV_STAGES; s++) begin
      rem_in[s]  = rem[s-1];
      dvsr_in[s] = dvsr[s-1];
      qacc_in[s] = qacc[s-1];
    end
  end

  always_comb begin
    logic [NUM_W-1:0] r;
    logic [NUM_W-1:0] sh;
    logic [QUO_W-1:0] q;
    int               idx;
    for (int s = 0; s < DIV_STAGES; s++) begin
      r = rem_in[s];
      q = qacc_in[s];
      for (int b = 0; b < BITS_PER_STAGE; b++) begin
        idx = QUO_W - 1 - s * BITS_PER_STAGE - b;
        sh  = NUM_W'(dvsr_in[s]) << idx;
        if (r >= sh) begin
          r      = r - sh;
          q[idx] = 1'b1;
        end
      end
      rem_next[s]  = r;
      qacc_next[s] = q;
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < DIV_STAGES; s++) begin
      if (en[s]) begin
        rem[s]  <= rem_next[s];
        dvsr[s] <= dvsr_in[s];
        qacc[s] <= qacc_next[s];
      end
    end
  end

  assign quo = qacc[DIV_STAGES-1];

endmodule

// ===== src/rgb_to_hsv_decompose.sv =====
`timescale 1ns / 1ps
// Top level of the RGB to HSV decompose pipeline.
// Depends on rhd_pkg, rhd_pixel_if, rhd_front, rhd_div, assert_macros.svh.
//
// Takes one RGB pixel per clock while the output is not stalled, and
// returns three 8-bit planes, in order: red/green/blue unchanged when the
// mode is 0, hue/saturation/value when it is 1. An accepted input beat
// passes through two front stages (max/min, then the dividends) and four
// divider stages that each resolve two quotient bits of the hue and
// saturation divisions before the output beat is offered. Each stage
// holds its item only while the stage after it is full and stalled, so a
// stalled output fills the pipe before input ready drops. The mode is
// sampled with each pixel; write it only while the pipe is empty.
`include "assert_macros.svh"
module rgb_to_hsv_decompose (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  rhd_pixel_if.sink   pixel,
  rhd_plane_if.source planes
);
  import rhd_pkg::*;

  localparam int LAST = PIPE_STAGES - 1;

  logic                   mode;
  logic [PIPE_STAGES-1:0] vld;
  logic [PIPE_STAGES-1:0] en;

  side_t                  side_f;
  side_t                  side_d [DIV_STAGES];
  logic [NUM_W-1:0]       num_hue;
  logic [DEN_W-1:0]       den_hue;
  logic [NUM_W-1:0]       num_sat;
  logic [DEN_W-1:0]       den_sat;
  logic [QUO_W-1:0]       hue;
  logic [QUO_W-1:0]       sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_RGB;
    end else if (cfg_wr_en) begin
      mode <= cfg_wr_data;
    end
  end

  // a stage loads when empty or when its contents move on
  always_comb begin
    en[LAST] = !vld[LAST] || planes.ready;
    for (int i = LAST - 1; i >= 0; i--) begin
      en[i] = !vld[i] || en[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (en[0]) vld[0] <= pixel.valid;
      for (int i = 1; i < PIPE_STAGES; i++) begin
        if (en[i]) vld[i] <= vld[i-1];
      end
    end
  end

  assign pixel.ready = en[0];

  rhd_front u_front (
    .clk     (clk),
    .en      (en[FRONT_STAGES-1:0]),
    .mode    (mode),
    .red     (pixel.red_in),
    .green   (pixel.green_in),
    .blue    (pixel.blue_in),
    .side    (side_f),
    .num_hue (num_hue),
    .den_hue (den_hue),
    .num_sat (num_sat),
    .den_sat (den_sat)
  );

  rhd_div u_div_hue (
    .clk (clk),
    .en  (en[LAST:FRONT_STAGES]),
    .num (num_hue),
    .den (den_hue),
    .quo (hue)
  );

  rhd_div u_div_sat (
    .clk (clk),
    .en  (en[LAST:FRONT_STAGES]),
    .num (num_sat),
    .den (den_sat),
    .quo (sat)
  );

  always_ff @(posedge clk) begin
    if (en[FRONT_STAGES]) side_d[0] <= side_f;
    for (int s = 1; s < DIV_STAGES; s++) begin
      if (en[FRONT_STAGES+s]) side_d[s] <= side_d[s-1];
    end
  end

  assign planes.valid        = vld[LAST];
  assign planes.first_plane  = (side_d[DIV_STAGES-1].mode == MODE_HSV) ?
                               hue : side_d[DIV_STAGES-1].red;
  assign planes.second_plane = (side_d[DIV_STAGES-1].mode == MODE_HSV) ?
                               sat : side_d[DIV_STAGES-1].green;
  assign planes.third_plane  = side_d[DIV_STAGES-1].third;

  // hue tops out at 254
  `RHD_ASSERT_NEVER(a_hue_range, clk, rst, vld[LAST] && (side_d[DIV_STAGES-1].mode == MODE_HSV) && (hue == {QUO_W{1'b1}}))
  // zero saturation means a grey pixel, so hue must be zero too
  `RHD_ASSERT(a_grey_hue, clk, rst, (vld[LAST] && (side_d[DIV_STAGES-1].mode == MODE_HSV) && (sat == '0)) |-> (hue == '0))
  // black pixel carries no saturation
  `RHD_ASSERT(a_black_sat, clk, rst, (vld[LAST] && (side_d[DIV_STAGES-1].mode == MODE_HSV) && (side_d[DIV_STAGES-1].third == '0)) |-> (sat == '0))
  // an accepted beat lands in the first stage
  `RHD_ASSERT(a_accept_load, clk, rst, (pixel.valid && pixel.ready) |=> vld[0])

endmodule
